### design/i2c_master_reg_access_top_macros.svh
// Assertion macros for the I2C register access master.
// Included by the top level; depends on nothing else.
`ifndef I2C_MASTER_REG_ACCESS_TOP_MACROS_SVH
`define I2C_MASTER_REG_ACCESS_TOP_MACROS_SVH

// same-cycle implication, held off during reset
`define I2CMRA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define I2CMRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/i2cmra_pkg.sv
// Shared types, codes and the phase script for the I2C register access master.
// No dependencies.
package i2cmra_pkg;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    REG_DEV_WR_ADDR = 2'd0,
    REG_DEV_RD_ADDR = 2'd1,
    REG_PHASE_TICKS = 2'd2
  } reg_idx_t;

  // bus segment kinds
  typedef enum logic [3:0] {
    SEG_START = 4'd0,
    SEG_DEVW  = 4'd1,
    SEG_REG   = 4'd2,
    SEG_DATA  = 4'd3,
    SEG_DEVR  = 4'd4,
    SEG_GAP   = 4'd5,
    SEG_CHK   = 4'd6,
    SEG_RECV  = 4'd7,
    SEG_MACK  = 4'd8,
    SEG_STOP  = 4'd9
  } seg_t;

  localparam logic [3:0]  RD_RECV_STEP = 4'd11;
  localparam logic [7:0]  DEV_WR_ADDR_RST = 8'h38;
  localparam logic [7:0]  DEV_RD_ADDR_RST = 8'h39;
  localparam logic [15:0] PHASE_TICKS_RST = 16'd16;

  typedef struct packed {
    logic [7:0]  dev_write_addr;
    logic [7:0]  dev_read_addr;
    logic [15:0] phase_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] reg_addr;
    logic [7:0] wdata;
    logic [7:0] count;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic       error;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       rx_last;
  } res_t;

  // segment sequence of a write or a burst read transfer
  function automatic seg_t seg_of(input logic [3:0] step, input logic rd);
    seg_t s;
    s = SEG_STOP;
    if (rd) begin
      unique case (step)
        4'd0:    s = SEG_START;
        4'd1:    s = SEG_DEVW;
        4'd2:    s = SEG_GAP;
        4'd3:    s = SEG_CHK;
        4'd4:    s = SEG_REG;
        4'd5:    s = SEG_GAP;
        4'd6:    s = SEG_CHK;
        4'd7:    s = SEG_START;
        4'd8:    s = SEG_DEVR;
        4'd9:    s = SEG_GAP;
        4'd10:   s = SEG_CHK;
        4'd11:   s = SEG_RECV;
        4'd12:   s = SEG_MACK;
        default: s = SEG_STOP;
      endcase
    end else begin
      unique case (step)
        4'd0:    s = SEG_START;
        4'd1:    s = SEG_DEVW;
        4'd2:    s = SEG_CHK;
        4'd3:    s = SEG_REG;
        4'd4:    s = SEG_CHK;
        4'd5:    s = SEG_DATA;
        4'd6:    s = SEG_CHK;
        default: s = SEG_STOP;
      endcase
    end
    return s;
  endfunction

endpackage

### design/i2cmra_core.sv
// Bus phase sequencer: holds the transfer state and works out one tick's bus
// levels and status. Depends on i2cmra_pkg.
module i2cmra_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  i2cmra_pkg::item_t  item,
  input  i2cmra_pkg::cfg_t   cfg,
  output i2cmra_pkg::res_t   res
);

  logic        busy_r, busy_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [1:0]  sub_r, sub_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  bleft_r, bleft_nxt;
  logic [7:0]  raddr_r, raddr_nxt;
  logic [7:0]  wdat_r, wdat_nxt;
  logic        rd_r, rd_nxt;
  logic        nack_r, nack_nxt;

  logic        start_cmd, run, ack, last_tick, do_enter;
  logic [3:0]  step_c, ent_step;
  logic [1:0]  sub_c;
  logic [15:0] tick_c, lim;
  logic [3:0]  bit_c;
  logic [7:0]  bleft_c, rx_shift;
  logic        rd_c, nack_c;
  i2cmra_pkg::seg_t seg, ent_seg;

  always_comb begin
    start_cmd = !busy_r && (item.cmd == i2cmra_pkg::CMD_WRITE ||
                            item.cmd == i2cmra_pkg::CMD_READ);
    run = busy_r || start_cmd;

    // state as seen this tick: an accepted command already starts phase one
    if (start_cmd) begin
      step_c    = 4'd0;
      sub_c     = 2'd0;
      tick_c    = 16'd0;
      bit_c     = 4'd0;
      bleft_c   = (item.count == 8'd0) ? 8'd1 : item.count;
      rd_c      = (item.cmd == i2cmra_pkg::CMD_READ);
      raddr_nxt = item.reg_addr;
      wdat_nxt  = item.wdata;
      nack_c    = 1'b0;
    end else begin
      step_c    = step_r;
      sub_c     = sub_r;
      tick_c    = tick_r;
      bit_c     = bit_r;
      bleft_c   = bleft_r;
      rd_c      = rd_r;
      raddr_nxt = raddr_r;
      wdat_nxt  = wdat_r;
      nack_c    = nack_r;
    end

    seg = i2cmra_pkg::seg_of(step_c, rd_c);
    ack = (bleft_c > 8'd1);

    // ack is sampled on the first tick of its SCL-high phase
    nack_nxt = nack_c;
    if (run && seg == i2cmra_pkg::SEG_CHK && sub_c == 2'd1 && tick_c == 16'd0) begin
      nack_nxt = item.sda_in;
    end

    res.scl      = 1'b1;
    res.sda_out  = 1'b1;
    res.busy_res = run;
    res.done_res = 1'b0;
    res.error    = 1'b0;
    res.rx_valid = 1'b0;
    res.rx_byte  = 8'd0;
    res.rx_last  = 1'b0;

    if (run) begin
      unique case (seg)
        i2cmra_pkg::SEG_START: begin
          res.scl     = (sub_c == 2'd0) ? (step_c == 4'd0) : (sub_c != 2'd3);
          res.sda_out = (sub_c < 2'd2);
        end
        i2cmra_pkg::SEG_DEVW, i2cmra_pkg::SEG_REG, i2cmra_pkg::SEG_DATA,
        i2cmra_pkg::SEG_DEVR: begin
          res.scl     = (sub_c == 2'd1);
          res.sda_out = shift_r[~bit_c[2:0]];
        end
        i2cmra_pkg::SEG_GAP: begin
          res.scl     = 1'b0;
          res.sda_out = shift_r[0];
        end
        i2cmra_pkg::SEG_CHK: begin
          res.scl     = sub_c[0];
          res.sda_out = 1'b1;
        end
        i2cmra_pkg::SEG_RECV: begin
          res.scl     = (sub_c == 2'd0) ? (bit_c != 4'd0) : (sub_c == 2'd2);
          res.sda_out = 1'b1;
        end
        i2cmra_pkg::SEG_MACK: begin
          res.scl     = (sub_c == 2'd1);
          res.sda_out = ack ? (sub_c == 2'd3) : (sub_c != 2'd3);
        end
        default: begin
          res.scl     = (sub_c == 2'd1 || sub_c == 2'd2);
          res.sda_out = (sub_c >= 2'd2);
        end
      endcase
    end

    lim       = (cfg.phase_ticks == 16'd0) ? 16'd1 : cfg.phase_ticks;
    last_tick = ({1'b0, tick_c} + 17'd1) >= {1'b0, lim};

    busy_nxt  = run;
    step_nxt  = step_c;
    sub_nxt   = sub_c;
    bit_nxt   = bit_c;
    shift_nxt = shift_r;
    bleft_nxt = bleft_c;
    rd_nxt    = rd_c;
    do_enter  = 1'b0;
    ent_step  = step_c + 4'd1;
    rx_shift  = {shift_r[6:0], item.sda_in};
    tick_nxt  = last_tick ? 16'd0 : tick_c + 16'd1;

    if (run && last_tick) begin
      unique case (seg)
        i2cmra_pkg::SEG_START, i2cmra_pkg::SEG_MACK, i2cmra_pkg::SEG_STOP: begin
          if (sub_c < 2'd3) begin
            sub_nxt = sub_c + 2'd1;
          end else if (seg == i2cmra_pkg::SEG_STOP) begin
            res.done_res = 1'b1;
            busy_nxt     = 1'b0;
          end else if (seg == i2cmra_pkg::SEG_MACK && ack) begin
            bleft_nxt = bleft_c - 8'd1;
            do_enter  = 1'b1;
            ent_step  = i2cmra_pkg::RD_RECV_STEP;
          end else begin
            do_enter = 1'b1;
          end
        end
        i2cmra_pkg::SEG_DEVW, i2cmra_pkg::SEG_REG, i2cmra_pkg::SEG_DATA,
        i2cmra_pkg::SEG_DEVR: begin
          if (sub_c < 2'd2) begin
            sub_nxt = sub_c + 2'd1;
          end else begin
            sub_nxt  = 2'd0;
            bit_nxt  = bit_c + 4'd1;
            do_enter = (bit_c[2:0] == 3'd7);
          end
        end
        i2cmra_pkg::SEG_GAP: begin
          do_enter = 1'b1;
        end
        i2cmra_pkg::SEG_CHK: begin
          if (sub_c == 2'd0) begin
            sub_nxt = sub_c + 2'd1;
          end else if (nack_nxt) begin
            res.done_res = 1'b1;
            res.error    = 1'b1;
            busy_nxt     = 1'b0;
          end else begin
            do_enter = 1'b1;
          end
        end
        default: begin
          if (sub_c < 2'd2) begin
            sub_nxt = sub_c + 2'd1;
          end else begin
            shift_nxt = rx_shift;
            sub_nxt   = 2'd0;
            bit_nxt   = bit_c + 4'd1;
            if (bit_c[2:0] == 3'd7) begin
              res.rx_valid = 1'b1;
              res.rx_byte  = rx_shift;
              res.rx_last  = (bleft_c <= 8'd1);
              do_enter     = 1'b1;
            end
          end
        end
      endcase
    end

    // entering a segment reloads the shift register for byte segments
    ent_seg = i2cmra_pkg::seg_of(ent_step, rd_c);
    if (do_enter) begin
      step_nxt = ent_step;
      sub_nxt  = 2'd0;
      bit_nxt  = 4'd0;
      unique case (ent_seg)
        i2cmra_pkg::SEG_DEVW: shift_nxt = cfg.dev_write_addr;
        i2cmra_pkg::SEG_REG:  shift_nxt = raddr_nxt;
        i2cmra_pkg::SEG_DATA: shift_nxt = wdat_nxt;
        i2cmra_pkg::SEG_DEVR: shift_nxt = cfg.dev_read_addr;
        i2cmra_pkg::SEG_RECV: shift_nxt = 8'd0;
        default:              shift_nxt = shift_nxt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      step_r  <= 4'd0;
      sub_r   <= 2'd0;
      tick_r  <= 16'd0;
      bit_r   <= 4'd0;
      shift_r <= 8'd0;
      bleft_r <= 8'd0;
      raddr_r <= 8'd0;
      wdat_r  <= 8'd0;
      rd_r    <= 1'b0;
      nack_r  <= 1'b0;
    end else if (en && run) begin
      busy_r  <= busy_nxt;
      step_r  <= step_nxt;
      sub_r   <= sub_nxt;
      tick_r  <= tick_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      bleft_r <= bleft_nxt;
      raddr_r <= raddr_nxt;
      wdat_r  <= wdat_nxt;
      rd_r    <= rd_nxt;
      nack_r  <= nack_nxt;
    end
  end

endmodule

### design/i2c_master_reg_access_top.sv
// I2C register access master: stream in/out wrapper, config registers, checks.
// Depends on i2cmra_pkg, i2cmra_core and i2c_master_reg_access_top_macros.svh.
//
// Every input transfer is one bus tick (command, register address, write byte,
// read count and the sampled SDA level) and yields exactly one result transfer
// (SCL and SDA drive, busy, done, error and any received byte). Sustained rate
// is one tick per clock cycle while out_tready is held high; a tick's result
// is registered: each tick passes the input register, then the single-pass
// phase sequencer, then the result register. Bus timing is counted in ticks:
// each phase lasts phase_ticks ticks (0 acts as 1). Config registers (APB, 0x0
// device write address, 0x4 device read address, 0x8 phase_ticks) should be
// written only while no transfer is running.
`include "i2c_master_reg_access_top_macros.svh"

module i2c_master_reg_access_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // reg_addr[7:0], wdata[15:8], count[23:16], sda_in[24]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // scl[0], sda_out[1], busy_res[2], done_res[3],
                                  // error[4], rx_valid[5], rx_byte[13:6]
  output logic        out_tlast,  // rx_last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  i2cmra_pkg::cfg_t  cfg_r;
  i2cmra_pkg::item_t in_item_r;
  i2cmra_pkg::res_t  res_c, out_res_r;
  logic              in_v_r, out_v_r;
  logic              adv, cfg_wr;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dev_write_addr <= i2cmra_pkg::DEV_WR_ADDR_RST;
      cfg_r.dev_read_addr  <= i2cmra_pkg::DEV_RD_ADDR_RST;
      cfg_r.phase_ticks    <= i2cmra_pkg::PHASE_TICKS_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        i2cmra_pkg::REG_DEV_WR_ADDR: cfg_r.dev_write_addr <= pwdata[7:0];
        i2cmra_pkg::REG_DEV_RD_ADDR: cfg_r.dev_read_addr  <= pwdata[7:0];
        i2cmra_pkg::REG_PHASE_TICKS: cfg_r.phase_ticks    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      i2cmra_pkg::REG_DEV_WR_ADDR: prdata = {24'd0, cfg_r.dev_write_addr};
      i2cmra_pkg::REG_DEV_RD_ADDR: prdata = {24'd0, cfg_r.dev_read_addr};
      i2cmra_pkg::REG_PHASE_TICKS: prdata = {16'd0, cfg_r.phase_ticks};
      default:                     prdata = 32'd0;
    endcase
  end

  // input register -> sequencer -> result register
  assign adv       = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_v_r <= 1'b1;
    end else if (adv) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.cmd      <= in_tuser;
      in_item_r.reg_addr <= in_tdata[7:0];
      in_item_r.wdata    <= in_tdata[15:8];
      in_item_r.count    <= in_tdata[23:16];
      in_item_r.sda_in   <= in_tdata[24];
    end
  end

  i2cmra_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .item  (in_item_r),
    .cfg   (cfg_r),
    .res   (res_c)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res_c;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, out_res_r.rx_byte, out_res_r.rx_valid, out_res_r.error,
                       out_res_r.done_res, out_res_r.busy_res, out_res_r.sda_out,
                       out_res_r.scl};
  assign out_tlast  = out_res_r.rx_last;

  `I2CMRA_ASSERT_IMP(a_err_with_done, clk, rst_n, out_v_r && out_res_r.error, out_res_r.done_res && out_res_r.busy_res, "error flagged without done on a busy tick")
  `I2CMRA_ASSERT_IMP(a_last_with_rx, clk, rst_n, out_v_r && out_res_r.rx_last, out_res_r.rx_valid && !out_res_r.done_res, "rx_last without a received byte")
  `I2CMRA_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !out_v_r, in_tready, "input stalled with empty result register")
  `I2CMRA_ASSERT_NEXT(a_done_lands, clk, rst_n, adv && res_c.done_res, out_v_r && out_res_r.done_res, "done tick lost on the way to the output")

endmodule

### verif/i2c_master_reg_access_top_tb.sv
// Self-checking testbench for the I2C register access master top level.
// Depends on i2cmra_pkg and i2c_master_reg_access_top; drives ticks, checks every result.
`timescale 1ns / 1ps

module i2c_master_reg_access_top_tb;
  import i2cmra_pkg::*;

  localparam logic [1:0] CMD_BAD = 2'd3;   // not a command, always ignored
  // acknowledge-check steps where a forced NACK can be placed
  localparam logic [3:0] NO_NACK     = 4'd15;
  localparam logic [3:0] WR_CHK_DEV  = 4'd2;
  localparam logic [3:0] WR_CHK_REG  = 4'd4;
  localparam logic [3:0] WR_CHK_DATA = 4'd6;
  localparam logic [3:0] RD_CHK_DEV  = 4'd3;
  localparam logic [3:0] RD_CHK_REG  = 4'd6;
  localparam logic [3:0] RD_CHK_DEVR = 4'd10;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_LEN    = 400;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] reg_addr;
    logic [7:0] wdata;
    logic [7:0] count;
    logic       sda;
    logic       respond;    // act as the slave on acknowledge checks
    logic       noisy_ack;  // occasional NACK on any check
    logic [3:0] nack_step;  // forced NACK at this step
  } bus_stim_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  i2c_master_reg_access_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // ---------------- bus master model ----------------
  logic [7:0]  dev_wr_mirror = DEV_WR_ADDR_RST;
  logic [7:0]  dev_rd_mirror = DEV_RD_ADDR_RST;
  logic [15:0] ticks_mirror  = PHASE_TICKS_RST;

  logic        m_busy = 1'b0;
  logic [3:0]  m_step = '0;
  logic [1:0]  m_sub = '0;
  logic [15:0] m_ticks = '0;
  logic [3:0]  m_nbit = '0;
  logic [7:0]  m_shift = '0;
  logic [7:0]  m_left = '0;
  logic [7:0]  m_raddr = '0;
  logic [7:0]  m_wbyte = '0;
  logic        m_rd = 1'b0;
  logic        m_nack = 1'b0;

  seg_t wr_seq [8] = '{SEG_START, SEG_DEVW, SEG_CHK, SEG_REG, SEG_CHK, SEG_DATA, SEG_CHK,
                       SEG_STOP};
  seg_t rd_seq [14] = '{SEG_START, SEG_DEVW, SEG_GAP, SEG_CHK, SEG_REG, SEG_GAP, SEG_CHK,
                        SEG_START, SEG_DEVR, SEG_GAP, SEG_CHK, SEG_RECV, SEG_MACK, SEG_STOP};

  function automatic seg_t seg_at(input logic [3:0] st, input logic rd);
    if (rd) return (st < 4'd14) ? rd_seq[st] : SEG_STOP;
    return (st < 4'd8) ? wr_seq[st] : SEG_STOP;
  endfunction

  function automatic void enter_step(input logic [3:0] st);
    m_step = st;
    m_sub  = 2'd0;
    m_nbit = 4'd0;
    case (seg_at(st, m_rd))
      SEG_DEVW: m_shift = dev_wr_mirror;
      SEG_REG:  m_shift = m_raddr;
      SEG_DATA: m_shift = m_wbyte;
      SEG_DEVR: m_shift = dev_rd_mirror;
      SEG_RECV: m_shift = 8'h00;
      default: ;
    endcase
  endfunction

  // one bus tick: returns the line levels and status the block must show for it
  function automatic res_t tick_bus_master(input item_t it);
    res_t        r;
    seg_t        seg;
    logic [1:0]  sub;
    logic        acking;
    logic [16:0] lim;
    r = '0;
    r.scl = 1'b1;
    r.sda_out = 1'b1;
    if (!m_busy) begin
      if (it.cmd == CMD_WRITE || it.cmd == CMD_READ) begin
        m_raddr = it.reg_addr;
        m_wbyte = it.wdata;
        m_left  = (it.count == 8'd0) ? 8'd1 : it.count;
        m_rd    = (it.cmd == CMD_READ);
        m_ticks = '0;
        m_nack  = 1'b0;
        m_busy  = 1'b1;
        enter_step(4'd0);
      end else begin
        return r;
      end
    end
    r.busy_res = 1'b1;
    seg = seg_at(m_step, m_rd);
    sub = m_sub;
    acking = (m_left > 8'd1);
    case (seg)
      SEG_START: begin
        r.scl = (sub == 2'd0) ? (m_step == 4'd0) : (sub != 2'd3);
        r.sda_out = (sub < 2'd2);
      end
      SEG_DEVW, SEG_REG, SEG_DATA, SEG_DEVR: begin
        r.scl = (sub == 2'd1);
        r.sda_out = m_shift[7 - m_nbit[2:0]];
      end
      SEG_GAP: begin
        r.scl = 1'b0;
        r.sda_out = m_shift[0];
      end
      SEG_CHK: begin
        r.scl = sub[0];
        r.sda_out = 1'b1;
        if (sub == 2'd1 && m_ticks == 16'd0) m_nack = it.sda_in;
      end
      SEG_RECV: begin
        r.scl = (sub == 2'd0) ? (m_nbit != 4'd0) : (sub == 2'd2);
        r.sda_out = 1'b1;
      end
      SEG_MACK: begin
        r.scl = (sub == 2'd1);
        r.sda_out = acking ? (sub == 2'd3) : (sub != 2'd3);
      end
      default: begin
        r.scl = (sub == 2'd1 || sub == 2'd2);
        r.sda_out = (sub >= 2'd2);
      end
    endcase

    lim = (ticks_mirror == 16'd0) ? 17'd1 : {1'b0, ticks_mirror};
    if ({1'b0, m_ticks} + 17'd1 < lim) begin
      m_ticks = m_ticks + 16'd1;
    end else begin
      m_ticks = '0;
      case (seg)
        SEG_START, SEG_MACK, SEG_STOP: begin
          if (sub < 2'd3) begin
            m_sub = m_sub + 2'd1;
          end else if (seg == SEG_STOP) begin
            r.done_res = 1'b1;
            m_busy = 1'b0;
          end else if (seg == SEG_MACK && acking) begin
            m_left = m_left - 8'd1;
            enter_step(RD_RECV_STEP);
          end else begin
            enter_step(m_step + 4'd1);
          end
        end
        SEG_DEVW, SEG_REG, SEG_DATA, SEG_DEVR: begin
          if (sub < 2'd2) begin
            m_sub = m_sub + 2'd1;
          end else begin
            m_sub = 2'd0;
            m_nbit = m_nbit + 4'd1;
            if (m_nbit >= 4'd8) enter_step(m_step + 4'd1);
          end
        end
        SEG_GAP: enter_step(m_step + 4'd1);
        SEG_CHK: begin
          if (sub == 2'd0) begin
            m_sub = m_sub + 2'd1;
          end else if (m_nack) begin
            r.done_res = 1'b1;
            r.error = 1'b1;
            m_busy = 1'b0;
          end else begin
            enter_step(m_step + 4'd1);
          end
        end
        default: begin
          if (sub < 2'd2) begin
            m_sub = m_sub + 2'd1;
          end else begin
            m_shift = {m_shift[6:0], it.sda_in};
            m_sub = 2'd0;
            m_nbit = m_nbit + 4'd1;
            if (m_nbit >= 4'd8) begin
              r.rx_valid = 1'b1;
              r.rx_byte = m_shift;
              r.rx_last = (m_left <= 8'd1);
              enter_step(m_step + 4'd1);
            end
          end
        end
      endcase
    end
    return r;
  endfunction

  // ---------------- driver ----------------
  bus_stim_t tick_q [$];
  res_t      bus_levels_q [$];
  item_t     cur_item = '0;
  logic      calm = 1'b0;
  logic      stall_go = 1'b0;
  int        n_pushed = 0;

  always @(posedge clk) begin : drive_ticks
    bus_stim_t s;
    logic      sda;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) bus_levels_q.push_back(tick_bus_master(cur_item));
      if (!in_tvalid || in_tready) begin
        if (tick_q.size() != 0 && (calm || $urandom_range(0, 99) >= 10)) begin
          s = tick_q.pop_front();
          sda = s.sda;
          // model state is now that of the tick about to be offered
          if (s.respond && m_busy && seg_at(m_step, m_rd) == SEG_CHK)
            sda = (m_step == s.nack_step) || (s.noisy_ack && $urandom_range(0, 39) == 0);
          cur_item.cmd = s.cmd;
          cur_item.reg_addr = s.reg_addr;
          cur_item.wdata = s.wdata;
          cur_item.count = s.count;
          cur_item.sda_in = sda;
          in_tdata  <= {7'd0, sda, s.count, s.wdata, s.reg_addr};
          in_tuser  <= s.cmd;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------- receiver ready ----------------
  int hold_cnt = 0;

  always @(posedge clk) begin
    if (stall_go && hold_cnt < HOLD_LEN) begin
      out_tready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else if (calm) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= 10);
    end
  end

  // ---------------- monitor ----------------
  int n_bad = 0;
  int n_checked = 0;
  int n_done = 0;
  int n_nacked = 0;
  int n_rx = 0;

  always @(posedge clk) begin : check_results
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.scl      = out_tdata[0];
      got.sda_out  = out_tdata[1];
      got.busy_res = out_tdata[2];
      got.done_res = out_tdata[3];
      got.error    = out_tdata[4];
      got.rx_valid = out_tdata[5];
      got.rx_byte  = out_tdata[13:6];
      got.rx_last  = out_tlast;
      n_checked++;
      if (got.done_res) n_done++;
      if (got.error) n_nacked++;
      if (got.rx_valid) n_rx++;
      if (bus_levels_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("ERROR: result transfer with nothing expected: %p", got);
      end else begin
        want = bus_levels_q.pop_front();
        if (got !== want) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("ERROR: tick %0d mismatch", n_checked);
            $display("  exp scl=%b sda=%b busy=%b done=%b err=%b rxv=%b rxb=%02h last=%b",
                     want.scl, want.sda_out, want.busy_res, want.done_res, want.error,
                     want.rx_valid, want.rx_byte, want.rx_last);
            $display("  got scl=%b sda=%b busy=%b done=%b err=%b rxv=%b rxb=%02h last=%b",
                     got.scl, got.sda_out, got.busy_res, got.done_res, got.error,
                     got.rx_valid, got.rx_byte, got.rx_last);
          end
        end
      end
    end
  end

  // ---------------- watchdog ----------------
  int cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------- register access ----------------
  task automatic check_reg(input reg_idx_t idx, input logic [31:0] want,
                           input logic [31:0] mask);
    logic [31:0] got;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if ((got & mask) !== want) begin
      n_bad++;
      if (n_bad <= 10) $display("ERROR: register %0d read %h, expected %h", idx, got, want);
    end
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val,
                           input logic [31:0] mask);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_DEV_WR_ADDR: dev_wr_mirror = val[7:0];
      REG_DEV_RD_ADDR: dev_rd_mirror = val[7:0];
      default:         ticks_mirror = val[15:0];
    endcase
    check_reg(idx, val & mask, mask);
  endtask

  task automatic set_bus(input logic [7:0] wa, input logic [7:0] ra, input logic [15:0] pt);
    write_reg(REG_DEV_WR_ADDR, {24'd0, wa}, 32'hFF);
    write_reg(REG_DEV_RD_ADDR, {24'd0, ra}, 32'hFF);
    write_reg(REG_PHASE_TICKS, {16'd0, pt}, 32'hFFFF);
  endtask

  // ---------------- stimulus helpers ----------------
  task automatic push_tick(input logic [1:0] c, input logic [7:0] ra, input logic [7:0] wd,
                           input logic [7:0] cnt, input logic sd, input logic resp,
                           input logic noisy, input logic [3:0] nk);
    bus_stim_t s;
    s.cmd = c;
    s.reg_addr = ra;
    s.wdata = wd;
    s.count = cnt;
    s.sda = sd;
    s.respond = resp;
    s.noisy_ack = noisy;
    s.nack_step = nk;
    tick_q.push_back(s);
    n_pushed++;
  endtask

  // tick during a transfer; wild adds real commands that may land while busy
  task automatic push_filler(input bit wild, input logic resp, input logic noisy,
                             input logic [3:0] nk);
    int         r;
    logic [1:0] c;
    r = $urandom_range(0, 99);
    if (wild) c = (r < 3) ? CMD_WRITE : (r < 6) ? CMD_READ : (r < 10) ? CMD_BAD : CMD_NONE;
    else      c = (r < 8) ? CMD_BAD : CMD_NONE;
    push_tick(c, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), resp, noisy, nk);
  endtask

  task automatic drain();
    while (tick_q.size() != 0 || in_tvalid || bus_levels_q.size() != 0) @(posedge clk);
  endtask

  task automatic run_until_idle(input bit wild, input logic resp, input logic noisy,
                                input logic [3:0] nk);
    do begin
      repeat (8) push_filler(wild, resp, noisy, nk);
      while (tick_q.size() >= 4) @(posedge clk);
    end while (m_busy);
  endtask

  // sender pauses until every result is in and the bus is back to idle
  task automatic settle_bus();
    drain();
    while (m_busy) begin
      repeat (64) push_filler(1'b0, 1'b1, 1'b0, NO_NACK);
      drain();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic directed_xfer(input logic [1:0] c, input logic [7:0] ra, input logic [7:0] wd,
                               input logic [7:0] cnt, input logic [3:0] nk);
    push_tick(c, ra, wd, cnt, 1'($urandom_range(0, 1)), 1'b1, 1'b0, nk);
    // second tick is always inside the transfer: this command must be ignored
    push_tick(CMD_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd3,
              1'($urandom_range(0, 1)), 1'b1, 1'b0, nk);
    run_until_idle(1'b0, 1'b1, 1'b0, nk);
    settle_bus();
  endtask

  task automatic random_traffic(input int span);
    int         stop_at;
    int         r;
    logic [7:0] cnt;
    logic       resp;
    stop_at = n_pushed + span;
    while (n_pushed < stop_at) begin
      r = $urandom_range(0, 99);
      cnt = (r < 25) ? 8'($urandom_range(5, 16)) : 8'($urandom_range(0, 4));
      // a few transfers see a slave that answers at random
      resp = ($urandom_range(0, 9) != 0);
      push_tick($urandom_range(0, 1) ? CMD_READ : CMD_WRITE, 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), cnt, 1'($urandom_range(0, 1)), resp, 1'b1,
                NO_NACK);
      if (!stall_go) stall_go <= 1'b1;
      run_until_idle(1'b1, resp, 1'b1, NO_NACK);
    end
    settle_bus();
  endtask

  // ---------------- test sequence ----------------
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    check_reg(REG_DEV_WR_ADDR, {24'd0, DEV_WR_ADDR_RST}, 32'hFF);
    check_reg(REG_DEV_RD_ADDR, {24'd0, DEV_RD_ADDR_RST}, 32'hFF);
    check_reg(REG_PHASE_TICKS, {16'd0, PHASE_TICKS_RST}, 32'hFFFF);

    // short phases; device addresses keep their reset values for now
    write_reg(REG_PHASE_TICKS, 32'd1, 32'hFFFF);

    // idle bus: no command and the reserved code do nothing
    push_tick(CMD_NONE, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b0, NO_NACK);
    push_tick(CMD_BAD, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, NO_NACK);
    push_tick(CMD_BAD, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b0, NO_NACK);
    push_tick(CMD_NONE, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, NO_NACK);
    directed_xfer(CMD_WRITE, 8'hFF, 8'h00, 8'h00, NO_NACK);
    directed_xfer(CMD_READ, 8'h3C, 8'h00, 8'd2, NO_NACK);

    set_bus(8'h00, 8'hFF, 16'd1);
    directed_xfer(CMD_READ, 8'hA5, 8'h5A, 8'd0, NO_NACK);
    directed_xfer(CMD_READ, 8'h5A, 8'hA5, 8'd1, NO_NACK);
    // missing acknowledge on each byte of a write and of a read
    directed_xfer(CMD_WRITE, 8'h12, 8'h34, 8'd0, WR_CHK_DEV);
    directed_xfer(CMD_WRITE, 8'h12, 8'h34, 8'd0, WR_CHK_REG);
    directed_xfer(CMD_WRITE, 8'h12, 8'h34, 8'd0, WR_CHK_DATA);
    directed_xfer(CMD_READ, 8'h56, 8'h00, 8'd4, RD_CHK_DEV);
    directed_xfer(CMD_READ, 8'h56, 8'h00, 8'd4, RD_CHK_REG);
    directed_xfer(CMD_READ, 8'h56, 8'h00, 8'd4, RD_CHK_DEVR);

    // zero phase length acts as one; run this part with no idling on either side
    calm <= 1'b1;
    set_bus(8'hFF, 8'h00, 16'd0);
    directed_xfer(CMD_READ, 8'h81, 8'h00, 8'd2, NO_NACK);
    calm <= 1'b0;

    set_bus(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'd1);
    random_traffic(80);
    set_bus(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
            16'($urandom_range(2, 3)));
    random_traffic(80);

    // slowest bus: only the start of one transfer fits in the run
    set_bus(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'hFFFF);
    push_tick(CMD_READ, 8'($urandom_range(0, 255)), 8'h00, 8'd2, 1'b0, 1'b1, 1'b0, NO_NACK);
    repeat (60) push_filler(1'b0, 1'b1, 1'b0, NO_NACK);
    drain();
    repeat (10) @(posedge clk);

    n_bad += bus_levels_q.size();
    $display("Checked %0d bus ticks with phase lengths from 0 to 65535 and changing addresses.",
             n_checked);
    $display("Transfers ended: %0d (%0d on a missing acknowledge), bytes received: %0d.",
             n_done, n_nacked, n_rx);
    if (n_bad == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", n_bad);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/i2cmra_pkg.sv
design/i2cmra_core.sv
design/i2c_master_reg_access_top.sv
verif/i2c_master_reg_access_top_tb.sv
